[sv/fatm_pkg.sv]
package fatm_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 4096;

   localparam int unsigned TYPE_W = 4;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned CFG_W  = 13;
   // Wide enough for an entry index one past the largest id.
   localparam int unsigned SIZE_W = WORD_W + 1;

   localparam logic [WORD_W-1:0] END_MARK      = 16'hffff;
   localparam logic [WORD_W-1:0] FREE_MARK     = 16'h0000;
   localparam logic [CFG_W-1:0]  ENTRIES_RESET = 13'd4096;

   typedef enum logic [TYPE_W-1:0] {
      CMD_READ       = 4'd0,
      CMD_WRITE      = 4'd1,
      CMD_TAKE       = 4'd2,
      CMD_FREE_NEXT  = 4'd3,
      CMD_FREE_CHAIN = 4'd4,
      CMD_TRUNCATE   = 4'd5,
      CMD_ALLOCATE   = 4'd6,
      CMD_EXTEND     = 4'd7,
      CMD_GET_NEXT   = 4'd8
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_WALK,
      ST_TRUNC_END,
      ST_FREE_TAIL,
      ST_SCAN,
      ST_LINK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic              no_free;
      logic              range_error;
   } rsp_word_type;

   // True when the id maps to an entry index below the table size in use.
   function automatic logic in_range(input logic [WORD_W-1:0] id,
                                     input logic [SIZE_W-1:0] size);
      return (({1'b0, id}) + SIZE_W'(1)) < size;
   endfunction

endpackage

[sv/fatm_if.sv]
interface fatm_req_if;
   import fatm_pkg::*;
   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [WORD_W-1:0]   cluster;
   logic [WORD_W-1:0]   value;
   modport source (output valid, output req_type, output cluster, output value, input ready);
   modport sink   (input valid, input req_type, input cluster, input value, output ready);
endinterface

interface fatm_rsp_if;
   import fatm_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   result;
   logic                no_free;
   logic                range_error;
   modport source (output valid, output result, output no_free, output range_error,
                   input ready);
   modport sink   (input valid, input result, input no_free, input range_error,
                   output ready);
endinterface

interface fatm_csr_if;
   import fatm_pkg::*;
   logic                valid;
   logic                ready;
   logic [CFG_W-1:0]    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/fatm_table.sv]
module fatm_table #(
   parameter int unsigned ENTRIES = fatm_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned AW      = $clog2(ENTRIES)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [fatm_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [fatm_pkg::WORD_W-1:0] rd_data
);
   import fatm_pkg::*;

   logic [WORD_W-1:0] mem [ENTRIES];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read of the entry written in the same cycle returns the new value.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/fatm_seq.sv]
module fatm_seq #(
   parameter int unsigned ENTRIES = fatm_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned AW      = $clog2(ENTRIES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fatm_pkg::SIZE_W-1:0] size,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fatm_pkg::TYPE_W-1:0] req_cmd,
   input  logic [fatm_pkg::WORD_W-1:0] req_cluster,
   input  logic [fatm_pkg::WORD_W-1:0] req_value,
   output logic                        done_valid,
   input  logic                        done_ready,
   output fatm_pkg::rsp_word_type      done_word,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output logic [fatm_pkg::WORD_W-1:0] wr_data,
   output logic [AW-1:0]               rd_addr,
   input  logic [fatm_pkg::WORD_W-1:0] rd_data
);
   import fatm_pkg::*;

   state_type         state_ff, state_in;
   logic [TYPE_W-1:0] cmd_ff, cmd_in;
   logic [AW-1:0]     entry_ff, entry_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [AW:0]       steps_ff, steps_in;
   logic [AW-1:0]     scan_ff, scan_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [WORD_W-1:0] res_ff, res_in;
   logic              nofree_ff, nofree_in;
   logic              rerr_ff, rerr_in;

   logic [AW-1:0]     req_addr;
   logic [AW-1:0]     nxt_addr;
   logic              nxt_ok;
   logic [AW:0]       steps_next;
   logic [AW:0]       scan_next;

   assign req_addr   = AW'({1'b0, req_cluster} + SIZE_W'(1));
   assign nxt_addr   = AW'({1'b0, rd_data} + SIZE_W'(1));
   assign nxt_ok     = in_range(rd_data, size);
   assign steps_next = steps_ff + 1'b1;
   assign scan_next  = {1'b0, scan_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      entry_ff  <= entry_in;
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
      scan_ff   <= scan_in;
      res_ff    <= res_in;
      nofree_ff <= nofree_in;
      rerr_ff   <= rerr_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      entry_in   = entry_ff;
      cur_in     = cur_ff;
      steps_in   = steps_ff;
      scan_in    = scan_ff;
      clr_in     = clr_ff;
      res_in     = res_ff;
      nofree_in  = nofree_ff;
      rerr_in    = rerr_ff;
      wr_en      = 1'b0;
      wr_addr    = entry_ff;
      wr_data    = FREE_MARK;
      rd_addr    = entry_ff;
      req_ready  = 1'b0;
      done_valid = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = req_cmd;
               entry_in  = req_addr;
               res_in    = '0;
               nofree_in = 1'b0;
               rerr_in   = 1'b0;
               steps_in  = '0;
               if ((req_cmd <= CMD_GET_NEXT) && (req_cmd != CMD_ALLOCATE) &&
                   !in_range(req_cluster, size)) begin
                  rerr_in  = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  case (req_cmd)
                     CMD_READ, CMD_FREE_NEXT, CMD_TRUNCATE, CMD_GET_NEXT: begin
                        rd_addr  = req_addr;
                        state_in = ST_LOOKUP;
                     end
                     CMD_WRITE: begin
                        wr_en    = 1'b1;
                        wr_addr  = req_addr;
                        wr_data  = req_value;
                        state_in = ST_RESP;
                     end
                     CMD_TAKE: begin
                        wr_en    = 1'b1;
                        wr_addr  = req_addr;
                        wr_data  = END_MARK;
                        state_in = ST_RESP;
                     end
                     CMD_FREE_CHAIN: begin
                        rd_addr  = req_addr;
                        cur_in   = req_addr;
                        state_in = ST_WALK;
                     end
                     CMD_ALLOCATE, CMD_EXTEND: begin
                        if (size < SIZE_W'(2)) begin
                           nofree_in = 1'b1;
                           state_in  = ST_RESP;
                        end else begin
                           rd_addr  = AW'(1);
                           scan_in  = AW'(1);
                           state_in = ST_SCAN;
                        end
                     end
                     default: begin
                        state_in = ST_RESP;
                     end
                  endcase
               end
            end
         end

         ST_LOOKUP: begin
            case (cmd_ff)
               CMD_READ: begin
                  res_in   = rd_data;
                  state_in = ST_RESP;
               end
               CMD_FREE_NEXT: begin
                  if (rd_data == END_MARK) begin
                     state_in = ST_RESP;
                  end else if (!nxt_ok) begin
                     rerr_in  = 1'b1;
                     state_in = ST_RESP;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = entry_ff;
                     wr_data  = END_MARK;
                     cur_in   = nxt_addr;
                     state_in = ST_FREE_TAIL;
                  end
               end
               CMD_TRUNCATE: begin
                  if (rd_data == END_MARK) begin
                     state_in = ST_TRUNC_END;
                  end else if (!nxt_ok) begin
                     rerr_in  = 1'b1;
                     state_in = ST_TRUNC_END;
                  end else begin
                     rd_addr  = nxt_addr;
                     cur_in   = nxt_addr;
                     state_in = ST_WALK;
                  end
               end
               CMD_GET_NEXT: begin
                  if (rd_data != END_MARK) begin
                     res_in   = rd_data;
                     state_in = ST_RESP;
                  end else begin
                     rd_addr  = AW'(1);
                     scan_in  = AW'(1);
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_WALK: begin
            // Clear the current link and fetch the next one in the same cycle.
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = FREE_MARK;
            steps_in = steps_next;
            if (rd_data != END_MARK && (SIZE_W'(steps_next) < size) && nxt_ok) begin
               rd_addr = nxt_addr;
               cur_in  = nxt_addr;
            end else begin
               if (rd_data != END_MARK) begin
                  rerr_in = 1'b1;
               end
               state_in = (cmd_ff == CMD_TRUNCATE) ? ST_TRUNC_END : ST_RESP;
            end
         end

         ST_TRUNC_END: begin
            wr_en    = 1'b1;
            wr_addr  = entry_ff;
            wr_data  = END_MARK;
            state_in = ST_RESP;
         end

         ST_FREE_TAIL: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = FREE_MARK;
            state_in = ST_RESP;
         end

         ST_SCAN: begin
            if (rd_data == FREE_MARK) begin
               wr_en    = 1'b1;
               wr_addr  = scan_ff;
               wr_data  = END_MARK;
               res_in   = WORD_W'(scan_ff) - WORD_W'(1);
               state_in = (cmd_ff == CMD_ALLOCATE) ? ST_RESP : ST_LINK;
            end else if (SIZE_W'(scan_next) >= size) begin
               nofree_in = 1'b1;
               state_in  = ST_RESP;
            end else begin
               scan_in = scan_next[AW-1:0];
               rd_addr = scan_next[AW-1:0];
            end
         end

         ST_LINK: begin
            wr_en    = 1'b1;
            wr_addr  = entry_ff;
            wr_data  = res_ff;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign done_word.result      = res_ff;
   assign done_word.no_free     = nofree_ff;
   assign done_word.range_error = rerr_ff;

endmodule

[sv/fat16_cluster_chain_manager_unit.sv]
// Channel   Direction  Carries                                  Word accepted when
// req_ch    in         req_type, cluster, value                 valid and ready high
// rsp_ch    out        result, no_free, range_error             valid and ready high
// csr_ch    in         entries_in_use (data)                    valid and ready high
//
// Reset starts a pass clearing the table one entry per cycle; request words wait for it,
// configuration words do not. Allocate, extend and a get_next that finds no link scan the
// table entry by entry; free_chain and truncate_after walk the chain link by link. The
// sequencer takes no new request word until the result of the last one is handed over, and
// a result waits in a register while the sink stalls.
module fat16_cluster_chain_manager_unit #(
   parameter int unsigned TABLE_ENTRIES = fatm_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   fatm_req_if.sink          req_ch,
   fatm_rsp_if.source        rsp_ch,
   fatm_csr_if.sink          csr_ch
);
   import fatm_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);

   // Configuration register holding the number of entries in use.
   logic [CFG_W-1:0]  entries_ff, entries_in;
   // Effective table size: the configured count clamped to the built depth.
   logic [SIZE_W-1:0] size;

   // Output register that parts the result side from the sequencer.
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              done_valid;
   logic              done_ready;
   rsp_word_type      done_word;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   // The register is always able to take a word.
   assign csr_ch.ready = 1'b1;
   assign entries_in   = (csr_ch.valid) ? csr_ch.data : entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else begin
         entries_ff <= entries_in;
      end
   end

   assign size = (SIZE_W'(entries_ff) > SIZE_W'(TABLE_ENTRIES)) ?
                 SIZE_W'(TABLE_ENTRIES) : SIZE_W'(entries_ff);

   // The sequencer may hand over a result whenever the output register is empty
   // or is being emptied in this cycle.
   assign done_ready   = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in = (done_valid && done_ready) ? 1'b1 :
                         (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_word_in  = (done_valid && done_ready) ? done_word : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result      = rsp_word_ff.result;
   assign rsp_ch.no_free     = rsp_word_ff.no_free;
   assign rsp_ch.range_error = rsp_word_ff.range_error;

   // The sequencer walks chains and scans for free entries through the table.
   fatm_seq #(
      .ENTRIES (TABLE_ENTRIES),
      .AW      (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .size        (size),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_cmd     (req_ch.req_type),
      .req_cluster (req_ch.cluster),
      .req_value   (req_ch.value),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_word   (done_word),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   // Allocation table: one write port and one registered read port, with the
   // written value forwarded when both ports address the same entry.
   fatm_table #(
      .ENTRIES (TABLE_ENTRIES),
      .AW      (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

[verif/fat16_cluster_chain_manager_unit_tb.sv]
module fat16_cluster_chain_manager_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fatm_pkg::*;

   // The table is sized as in the default build of the block.
   localparam int unsigned TABLE_DEPTH = TABLE_ENTRIES_DEF;

   // Request types above the last command are to be ignored by the block.
   localparam logic [TYPE_W-1:0] CMD_UNKNOWN_FIRST = 4'd9;
   localparam logic [TYPE_W-1:0] CMD_UNKNOWN_LAST  = 4'd15;

   localparam int unsigned HALF_PERIOD   = 10;
   localparam int unsigned IDLE_PCT      = 31;
   localparam int unsigned MAX_SHOWN     = 10;
   localparam int unsigned SETTLE_CYCLES = 100;
   // Reckoned from a worst case of some hundred items each walking the whole
   // table, plus the clearing pass after reset, and then taken several times.
   localparam int unsigned LIMIT_NS      = 50_000_000;

   // Result words that can be read straight off the command.
   localparam rsp_word_type QUIET        = '{16'h0000, 1'b0, 1'b0};
   localparam rsp_word_type NO_ROOM      = '{16'h0000, 1'b1, 1'b0};
   localparam rsp_word_type OUT_OF_RANGE = '{16'h0000, 1'b0, 1'b1};

   // Random phases: the table size in use and the number of request words.
   // Most phases keep the table small, so that scans and walks stay short and
   // the table fills up often enough for allocation to run dry. The two large
   // settings (the reset value and the largest the register holds, which the
   // block clamps) get few words, since a walk there may cover the whole table.
   localparam int unsigned PHASES = 11;
   localparam int unsigned PHASE_SIZE  [PHASES] = '{16, 2, 33, 4096, 5, 64, 8191, 1,
                                                    9, 24, 3};
   localparam int unsigned PHASE_WORDS [PHASES] = '{120, 60, 120, 40, 100, 140, 30, 30,
                                                    110, 140, 60};
   // The phase run with neither side idling, and the one with a full drain
   // part-way through.
   localparam int unsigned CALM_PHASE  = 5;
   localparam int unsigned DRAIN_PHASE = 2;
   localparam int unsigned DRAIN_AT    = 60;

   // One row of the directed part. A row either writes the table size (held in
   // value) or sends one request word; a typed result word, where one is
   // given, stands in for the predicted one.
   typedef struct {
      bit                set_size;
      logic [TYPE_W-1:0] op;
      logic [WORD_W-1:0] cluster;
      logic [WORD_W-1:0] value;
      bit                known;
      rsp_word_type      word;
   } step_row_type;

   localparam int unsigned PLAN_ROWS = 27;
   step_row_type plan [PLAN_ROWS] = '{
      // Start from the reset size, written once so the register sees it.
      '{1'b1, CMD_READ,          16'h0000, 16'd4096, 1'b0, QUIET},
      // A freshly cleared table reads zero up to its last entry.
      '{1'b0, CMD_READ,          16'h0000, 16'h0000, 1'b1, QUIET},
      '{1'b0, CMD_READ,          16'd4094, 16'h0000, 1'b1, QUIET},
      // One past the last id, and the largest id, which must not wrap.
      '{1'b0, CMD_READ,          16'd4095, 16'h0000, 1'b1, OUT_OF_RANGE},
      '{1'b0, CMD_WRITE,         16'hffff, 16'h1234, 1'b1, OUT_OF_RANGE},
      // Allocation starts above the reserved entry, so the first id is zero.
      '{1'b0, CMD_ALLOCATE,      16'h0000, 16'h0000, 1'b1, QUIET},
      '{1'b0, CMD_ALLOCATE,      16'h0000, 16'h0000, 1'b1, '{16'h0001, 1'b0, 1'b0}},
      // Build a chain 0 -> 2 -> 3 -> 4, then cut and free it in pieces.
      '{1'b0, CMD_EXTEND,        16'h0000, 16'h0000, 1'b0, QUIET},
      '{1'b0, CMD_EXTEND,        16'h0002, 16'h0000, 1'b0, QUIET},
      '{1'b0, CMD_GET_NEXT,      16'h0003, 16'h0000, 1'b0, QUIET},
      '{1'b0, CMD_FREE_NEXT,     16'h0003, 16'h0000, 1'b0, QUIET},
      '{1'b0, CMD_TRUNCATE,      16'h0000, 16'h0000, 1'b0, QUIET},
      '{1'b0, CMD_FREE_CHAIN,    16'h0000, 16'h0000, 1'b0, QUIET},
      '{1'b0, CMD_TAKE,          16'd4094, 16'h0000, 1'b1, QUIET},
      // An entry naming an id outside the table blocks free_next.
      '{1'b0, CMD_WRITE,         16'h0014, 16'h0fff, 1'b0, QUIET},
      '{1'b0, CMD_FREE_NEXT,     16'h0014, 16'h0000, 1'b1, OUT_OF_RANGE},
      '{1'b0, CMD_FREE_CHAIN,    16'hffff, 16'h0000, 1'b1, OUT_OF_RANGE},
      // Unknown request types do nothing, even with an id out of range.
      '{1'b0, CMD_UNKNOWN_FIRST, 16'hffff, 16'hffff, 1'b1, QUIET},
      '{1'b0, CMD_UNKNOWN_LAST,  16'h0000, 16'hffff, 1'b1, QUIET},
      // The smallest sense-making table holds one cluster: fill it and then
      // find every allocating command refused.
      '{1'b1, CMD_READ,          16'h0000, 16'd2,    1'b0, QUIET},
      '{1'b0, CMD_ALLOCATE,      16'h0000, 16'h0000, 1'b0, QUIET},
      '{1'b0, CMD_ALLOCATE,      16'h0000, 16'h0000, 1'b1, NO_ROOM},
      '{1'b0, CMD_EXTEND,        16'h0000, 16'h0000, 1'b1, NO_ROOM},
      '{1'b0, CMD_GET_NEXT,      16'h0000, 16'h0000, 1'b1, NO_ROOM},
      '{1'b0, CMD_READ,          16'h0001, 16'h0000, 1'b1, OUT_OF_RANGE},
      // Freeing leaves a zero entry, which names cluster 0 again: the walk of
      // truncate_after then circles until it runs out of steps.
      '{1'b0, CMD_FREE_CHAIN,    16'h0000, 16'h0000, 1'b0, QUIET},
      '{1'b0, CMD_TRUNCATE,      16'h0000, 16'h0000, 1'b0, QUIET}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   fatm_req_if req_ch ();
   fatm_rsp_if rsp_ch ();
   fatm_csr_if csr_ch ();

   fat16_cluster_chain_manager_unit #(
      .TABLE_ENTRIES (TABLE_DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Our own copy of the allocation table and of the size register, kept in
   // step with every word the block accepts.
   logic [WORD_W-1:0] fat_mirror [TABLE_DEPTH];
   logic [CFG_W-1:0]  mirror_size;
   rsp_word_type      words_due [$];
   int unsigned       mismatches = 0;

   // Idling controls, and the typed result word that travels with the
   // request word currently on offer.
   bit           req_calm = 1'b0;
   bit           rsp_calm = 1'b0;
   logic         sink_ready = 1'b0;
   bit           tag_known;
   rsp_word_type tag_word;

   assign rsp_ch.ready = sink_ready;

   // The register may hold more than the table has; the block clamps it.
   function automatic int unsigned live_entries();
      if (mirror_size > TABLE_DEPTH)
         return TABLE_DEPTH;
      return mirror_size;
   endfunction

   // Cluster id n lives in entry n+1, which must fall below the live size.
   function automatic bit id_ok(input int unsigned id);
      return id + 1 < live_entries();
   endfunction

   // Clears a chain from the given cluster onwards. A walk that leaves the
   // table or takes more steps than there are entries reports a fault, and
   // what it has cleared so far stays cleared.
   function automatic bit release_chain(input int unsigned start);
      int unsigned cur;
      int unsigned nxt;
      int unsigned steps;
      cur   = start;
      steps = 0;
      while (cur != END_MARK) begin
         if (steps >= live_entries() || !id_ok(cur))
            return 1'b1;
         nxt = fat_mirror[cur + 1];
         fat_mirror[cur + 1] = FREE_MARK;
         cur = nxt;
         steps++;
      end
      return 1'b0;
   endfunction

   // Takes the lowest free entry above the reserved one and marks it as the
   // end of a chain.
   function automatic bit claim_free(output int unsigned id);
      id = 0;
      for (int unsigned e = 1; e < live_entries(); e++) begin
         if (fat_mirror[e] == FREE_MARK) begin
            fat_mirror[e] = END_MARK;
            id = e - 1;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Carries out one command on the mirror and returns the result word that
   // the block owes for it.
   function automatic rsp_word_type apply_command(input logic [TYPE_W-1:0] op,
                                                  input logic [WORD_W-1:0] cl,
                                                  input logic [WORD_W-1:0] val);
      rsp_word_type r;
      int unsigned  e;
      int unsigned  nxt;
      int unsigned  id;
      r = QUIET;
      if (op <= CMD_GET_NEXT && op != CMD_ALLOCATE && !id_ok(cl)) begin
         r.range_error = 1'b1;
      end else begin
         e = cl + 1;
         case (op)
            CMD_READ: begin
               r.result = fat_mirror[e];
            end
            CMD_WRITE: begin
               fat_mirror[e] = val;
            end
            CMD_TAKE: begin
               fat_mirror[e] = END_MARK;
            end
            CMD_FREE_NEXT: begin
               nxt = fat_mirror[e];
               if (nxt != END_MARK) begin
                  if (!id_ok(nxt)) begin
                     r.range_error = 1'b1;
                  end else begin
                     fat_mirror[e]       = END_MARK;
                     fat_mirror[nxt + 1] = FREE_MARK;
                  end
               end
            end
            CMD_FREE_CHAIN: begin
               r.range_error = release_chain(cl);
            end
            CMD_TRUNCATE: begin
               // The entry is closed off even when the walk faults.
               r.range_error = release_chain(fat_mirror[e]);
               fat_mirror[e] = END_MARK;
            end
            CMD_ALLOCATE: begin
               if (claim_free(id))
                  r.result = WORD_W'(id);
               else
                  r.no_free = 1'b1;
            end
            CMD_EXTEND, CMD_GET_NEXT: begin
               // get_next only allocates at the end of a chain.
               if (op == CMD_GET_NEXT && fat_mirror[e] != END_MARK) begin
                  r.result = fat_mirror[e];
               end else if (claim_free(id)) begin
                  fat_mirror[e] = WORD_W'(id);
                  r.result      = WORD_W'(id);
               end else begin
                  r.no_free = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   // Everything is sampled at the rising edge, before the block's own
   // registers move. A result word is checked before the request word of the
   // same edge is predicted; the two can never belong to the same command.
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         foreach (fat_mirror[i])
            fat_mirror[i] = FREE_MARK;
         mirror_size = ENTRIES_RESET;
         words_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.result, rsp_ch.no_free, rsp_ch.range_error};
            if (words_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("%0t: result word with none outstanding: result %h no_free %b "
                           , $time, got.result, got.no_free,
                           "range_error %b", got.range_error);
            end else begin
               want = words_due.pop_front();
               if (got.result !== want.result || got.no_free !== want.no_free ||
                   got.range_error !== want.range_error) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("%0t: result %h/%h no_free %b/%b range_error %b/%b",
                              $time, want.result, got.result, want.no_free, got.no_free,
                              want.range_error, got.range_error,
                              " (expected/actual)");
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready)
            mirror_size = csr_ch.data;
         if (req_ch.valid && req_ch.ready) begin
            want = apply_command(req_ch.req_type, req_ch.cluster, req_ch.value);
            words_due.push_back(tag_known ? tag_word : want);
         end
      end
   end

   // The receiving side stalls at random, except while told to stay calm.
   always @(negedge clock)
      sink_ready <= rsp_calm || ($urandom_range(0, 99) >= IDLE_PCT);

   // Offers one request word, after a random gap unless the sender is calm,
   // and returns at the falling edge after it has been taken. Valid stays
   // high for a following word sent without a gap.
   task automatic send_word(input logic [TYPE_W-1:0] op, input logic [WORD_W-1:0] cl,
                            input logic [WORD_W-1:0] val, input bit known,
                            input rsp_word_type typed);
      int unsigned gap;
      gap = 0;
      if (!req_calm)
         while ($urandom_range(0, 99) < IDLE_PCT)
            gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= op;
      req_ch.cluster  <= cl;
      req_ch.value    <= val;
      tag_known       <= known;
      tag_word        <= typed;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Holds the sender back until every owed result word has come. Each
   // command owes exactly one, so the block is idle once the queue is empty.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (words_due.size() != 0)
         @(negedge clock);
   endtask

   // The size register is only written while the block has nothing in hand.
   task automatic write_size(input logic [CFG_W-1:0] size);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= size;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      int unsigned       span;
      int unsigned       pick;
      logic [TYPE_W-1:0] op;
      logic [WORD_W-1:0] cl;
      logic [WORD_W-1:0] val;

      req_ch.valid    = 1'b0;
      req_ch.req_type = CMD_READ;
      req_ch.cluster  = '0;
      req_ch.value    = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.data     = ENTRIES_RESET;
      tag_known       = 1'b0;
      tag_word        = QUIET;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed part. The block clears its table after reset; the first request
      // word simply waits for that.
      foreach (plan[i]) begin
         if (plan[i].set_size)
            write_size(CFG_W'(plan[i].value));
         else
            send_word(plan[i].op, plan[i].cluster, plan[i].value, plan[i].known,
                      plan[i].word);
      end

      // Random part. Most words are well-formed commands on ids inside the
      // table, so that real chains get built, walked and freed; the rest are
      // ids on or past the boundary, arbitrary ids and unknown types.
      for (int unsigned ph = 0; ph < PHASES; ph++) begin
         write_size(CFG_W'(PHASE_SIZE[ph]));
         span     = (PHASE_SIZE[ph] > TABLE_DEPTH) ? TABLE_DEPTH : PHASE_SIZE[ph];
         req_calm = (ph == CALM_PHASE);
         rsp_calm = (ph == CALM_PHASE);
         for (int unsigned i = 0; i < PHASE_WORDS[ph]; i++) begin
            if (ph == DRAIN_PHASE && i == DRAIN_AT)
               wait_drained();

            pick = $urandom_range(0, 99);
            if (pick < 10)
               op = CMD_READ;
            else if (pick < 20)
               op = CMD_WRITE;
            else if (pick < 26)
               op = CMD_TAKE;
            else if (pick < 34)
               op = CMD_FREE_NEXT;
            else if (pick < 42)
               op = CMD_FREE_CHAIN;
            else if (pick < 50)
               op = CMD_TRUNCATE;
            else if (pick < 66)
               op = CMD_ALLOCATE;
            else if (pick < 78)
               op = CMD_EXTEND;
            else if (pick < 94)
               op = CMD_GET_NEXT;
            else if (pick < 97)
               op = TYPE_W'($urandom_range(0, 15));
            else
               op = TYPE_W'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));

            pick = $urandom_range(0, 99);
            if (span >= 2 && pick < 80)
               cl = WORD_W'($urandom_range(0, span - 2));
            else if (pick < 88)
               cl = WORD_W'(span - 1);
            else if (pick < 92)
               cl = 16'hffff;
            else
               cl = WORD_W'($urandom);

            // Half of the written values name a cluster in the table or end a
            // chain; the rest are free marks and arbitrary words.
            pick = $urandom_range(0, 99);
            if (span >= 2 && pick < 35)
               val = WORD_W'($urandom_range(0, span - 2));
            else if (pick < 50)
               val = END_MARK;
            else if (pick < 58)
               val = FREE_MARK;
            else
               val = WORD_W'($urandom);

            send_word(op, cl, val, 1'b0, QUIET);
         end
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;

      // Let every owed word arrive, then watch a while for strays.
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatches == 0 && words_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Hard stop should the block hang.
   initial begin
      #(LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule
